// ----- rtl/flow_rate_leak_classifier_top_macros.svh -----
// Assertion macros for the flow rate and leak classifier.
`ifndef FLOW_RATE_LEAK_CLASSIFIER_TOP_MACROS_SVH
`define FLOW_RATE_LEAK_CLASSIFIER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define FRLC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FRLC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FRLC_ASSERT_NOW(label, clk, rstn, ante, cons)
`define FRLC_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/frlc_pkg.sv -----
// Types, constants and register codes of the flow rate and leak classifier.
`timescale 1ns / 1ps
`default_nettype none
package frlc_pkg;

    localparam int RUN_COUNT_WIDTH   = 8;
    localparam int PULSE_FIELD_WIDTH = 16;
    localparam int CMP_WIDTH         = 16;

    localparam int DIV_WIDTH  = 39;
    localparam int DEN_WIDTH  = 28;
    localparam int PPL_WIDTH  = 12;
    localparam int STEP_WIDTH = $clog2(DIV_WIDTH);

    localparam logic [DIV_WIDTH-1:0] RATE_SCALE = DIV_WIDTH'(6000000);
    localparam logic [DIV_WIDTH-1:0] VOL_SCALE  = DIV_WIDTH'(1000000);
    localparam logic [15:0] PULSE_MASK = 16'((64'd1 << PULSE_FIELD_WIDTH) - 64'd1);
    localparam logic [RUN_COUNT_WIDTH-1:0] RUN_MAX = '1;

    typedef logic [RUN_COUNT_WIDTH-1:0] run_t;
    typedef logic [CMP_WIDTH-1:0] cmp_t;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_ACTIVE = 2'd1;
    localparam logic [1:0] MODE_LEAK   = 2'd2;

    localparam logic [2:0] REG_PULSES_PER_LITER = 3'd0;
    localparam logic [2:0] REG_DETECT_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_LEAK_THRESHOLD   = 3'd2;
    localparam logic [2:0] REG_CONFIRM_CYCLES   = 3'd3;
    localparam logic [2:0] REG_IDLE_CYCLES      = 3'd4;
    localparam logic [2:0] REG_ALERT_CYCLES     = 3'd5;

    typedef struct packed {
        logic [15:0] pulse_tally;
        logic [15:0] period_length_ms;
    } in_word_t;

    typedef struct packed {
        logic [15:0] flow_rate_centi;
        logic [1:0]  flow_mode;
        logic        flow_present;
        logic        leak_alert;
        logic [31:0] pulses_total;
        logic [47:0] volume_total_ul;
    } out_word_t;

endpackage
`default_nettype wire

// ----- rtl/flow_rate_leak_classifier_top.sv -----
// Flow rate and leak classifier top level.
// An input word is taken in the idle state, then two restoring dividers retire one quotient bit
// per cycle each, then the classify step (S_FIN) classifies and loads the output register.
// A new word is accepted only in the idle state, after the previous word has been classified
// and loaded into the output register. A full output register stalls the classify step.
// Reset is synchronous, active low, restores configuration defaults and clears control state.
`timescale 1ns / 1ps
`default_nettype none
`include "flow_rate_leak_classifier_top_macros.svh"
module flow_rate_leak_classifier_top (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire frlc_pkg::in_word_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output frlc_pkg::out_word_t      m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [15:0]         cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_FIN} state_t;

    state_t state_reg;

    logic [frlc_pkg::PPL_WIDTH-1:0] ppl_reg;
    logic [15:0] detect_reg;
    logic [15:0] leak_thr_reg;
    logic [7:0]  confirm_reg;
    logic [7:0]  idle_limit_reg;
    logic [7:0]  alert_cycles_reg;

    logic [1:0]       mode_reg, mode_next;
    logic             detected_reg, detected_next;
    frlc_pkg::run_t   active_run_reg, active_run_next;
    frlc_pkg::run_t   idle_run_reg, idle_run_next;
    frlc_pkg::run_t   leak_run_reg, leak_run_next;
    frlc_pkg::run_t   cooldown_reg, cooldown_next;
    logic             alert_next;
    logic [31:0]      pulse_acc_reg, pulse_acc_next;
    logic [47:0]      vol_acc_reg, vol_acc_next;

    logic [15:0]                        pulses_reg;
    logic [frlc_pkg::DIV_WIDTH-1:0]     rnq_reg, vnq_reg;
    logic [frlc_pkg::DEN_WIDTH-1:0]     rrem_reg, rden_reg;
    logic [frlc_pkg::PPL_WIDTH-1:0]     vrem_reg;
    logic [frlc_pkg::STEP_WIDTH-1:0]    step_reg;

    logic                               m_valid_reg;
    frlc_pkg::out_word_t                m_data_reg;

    logic [frlc_pkg::DEN_WIDTH:0]       rtrial;
    logic                               rbit;
    logic [frlc_pkg::PPL_WIDTH:0]       vtrial;
    logic                               vbit;
    logic [15:0]                        rate;
    logic [15:0]                        pulses_in;
    logic                               out_free;

    function automatic frlc_pkg::run_t sat_inc(input frlc_pkg::run_t v);
        return (v == frlc_pkg::RUN_MAX) ? frlc_pkg::RUN_MAX : frlc_pkg::run_t'(v + 1'b1);
    endfunction

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign pulses_in = s_data.pulse_tally & frlc_pkg::PULSE_MASK;

    always_comb begin
        rtrial = {rrem_reg, rnq_reg[frlc_pkg::DIV_WIDTH-1]};
        rbit   = (rtrial >= {1'b0, rden_reg});
        vtrial = {vrem_reg, vnq_reg[frlc_pkg::DIV_WIDTH-1]};
        vbit   = (vtrial >= {1'b0, ppl_reg});
    end

    always_comb begin
        if (rden_reg == '0) begin
            rate = '0;
        end else if (rnq_reg[frlc_pkg::DIV_WIDTH-1:16] != '0) begin
            rate = 16'hFFFF;
        end else begin
            rate = rnq_reg[15:0];
        end
    end

    always_comb begin
        mode_next       = mode_reg;
        detected_next   = detected_reg;
        active_run_next = active_run_reg;
        idle_run_next   = idle_run_reg;
        leak_run_next   = leak_run_reg;
        cooldown_next   = cooldown_reg;
        alert_next      = 1'b0;
        pulse_acc_next  = pulse_acc_reg + 32'(pulses_reg);
        vol_acc_next    = vol_acc_reg;
        if (ppl_reg != '0) begin
            vol_acc_next = vol_acc_reg + 48'(vnq_reg);
        end
        if (rate >= detect_reg) begin
            idle_run_next   = '0;
            active_run_next = sat_inc(active_run_reg);
            if (frlc_pkg::cmp_t'(active_run_next) >= frlc_pkg::cmp_t'(confirm_reg)) begin
                if (rate < leak_thr_reg) begin
                    mode_next     = frlc_pkg::MODE_LEAK;
                    leak_run_next = sat_inc(leak_run_reg);
                    if ((frlc_pkg::cmp_t'(leak_run_next) >= frlc_pkg::cmp_t'(alert_cycles_reg))
                        && (cooldown_reg == '0)) begin
                        alert_next    = 1'b1;
                        leak_run_next = '0;
                        if (frlc_pkg::cmp_t'(alert_cycles_reg)
                            > frlc_pkg::cmp_t'(frlc_pkg::RUN_MAX)) begin
                            cooldown_next = frlc_pkg::RUN_MAX;
                        end else begin
                            cooldown_next = frlc_pkg::run_t'(alert_cycles_reg);
                        end
                    end
                    if (cooldown_next != '0) begin
                        cooldown_next = cooldown_next - 1'b1;
                    end
                end else begin
                    mode_next     = frlc_pkg::MODE_ACTIVE;
                    detected_next = 1'b1;
                    leak_run_next = '0;
                    cooldown_next = '0;
                end
            end
        end else begin
            active_run_next = '0;
            idle_run_next   = sat_inc(idle_run_reg);
            leak_run_next   = '0;
            if (frlc_pkg::cmp_t'(idle_run_next) >= frlc_pkg::cmp_t'(idle_limit_reg)) begin
                mode_next     = frlc_pkg::MODE_IDLE;
                detected_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            m_valid_reg      <= 1'b0;
            ppl_reg          <= 12'd450;
            detect_reg       <= 16'd10;
            leak_thr_reg     <= 16'd50;
            confirm_reg      <= 8'd3;
            idle_limit_reg   <= 8'd3;
            alert_cycles_reg <= 8'd10;
            mode_reg         <= frlc_pkg::MODE_IDLE;
            detected_reg     <= 1'b0;
            active_run_reg   <= '0;
            idle_run_reg     <= '0;
            leak_run_reg     <= '0;
            cooldown_reg     <= '0;
            pulse_acc_reg    <= '0;
            vol_acc_reg      <= '0;
            step_reg         <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    frlc_pkg::REG_PULSES_PER_LITER: ppl_reg <= cfg_data[11:0];
                    frlc_pkg::REG_DETECT_THRESHOLD: detect_reg <= cfg_data;
                    frlc_pkg::REG_LEAK_THRESHOLD:   leak_thr_reg <= cfg_data;
                    frlc_pkg::REG_CONFIRM_CYCLES:   confirm_reg <= cfg_data[7:0];
                    frlc_pkg::REG_IDLE_CYCLES:      idle_limit_reg <= cfg_data[7:0];
                    frlc_pkg::REG_ALERT_CYCLES:     alert_cycles_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready && (state_reg != S_FIN)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        pulses_reg <= pulses_in;
                        rnq_reg    <= frlc_pkg::DIV_WIDTH'(pulses_in) * frlc_pkg::RATE_SCALE;
                        vnq_reg    <= frlc_pkg::DIV_WIDTH'(pulses_in) * frlc_pkg::VOL_SCALE;
                        rden_reg   <= frlc_pkg::DEN_WIDTH'(ppl_reg)
                                      * frlc_pkg::DEN_WIDTH'(s_data.period_length_ms);
                        rrem_reg   <= '0;
                        vrem_reg   <= '0;
                        step_reg   <= '0;
                        state_reg  <= S_DIV;
                    end
                end
                S_DIV: begin
                    rrem_reg <= rbit ? frlc_pkg::DEN_WIDTH'(rtrial - {1'b0, rden_reg})
                                     : rtrial[frlc_pkg::DEN_WIDTH-1:0];
                    rnq_reg  <= {rnq_reg[frlc_pkg::DIV_WIDTH-2:0], rbit};
                    vrem_reg <= vbit ? frlc_pkg::PPL_WIDTH'(vtrial - {1'b0, ppl_reg})
                                     : vtrial[frlc_pkg::PPL_WIDTH-1:0];
                    vnq_reg  <= {vnq_reg[frlc_pkg::DIV_WIDTH-2:0], vbit};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == frlc_pkg::STEP_WIDTH'(frlc_pkg::DIV_WIDTH - 1)) begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        mode_reg       <= mode_next;
                        detected_reg   <= detected_next;
                        active_run_reg <= active_run_next;
                        idle_run_reg   <= idle_run_next;
                        leak_run_reg   <= leak_run_next;
                        cooldown_reg   <= cooldown_next;
                        pulse_acc_reg  <= pulse_acc_next;
                        vol_acc_reg    <= vol_acc_next;
                        m_valid_reg    <= 1'b1;
                        m_data_reg.flow_rate_centi <= rate;
                        m_data_reg.flow_mode       <= mode_next;
                        m_data_reg.flow_present    <= detected_next;
                        m_data_reg.leak_alert      <= alert_next;
                        m_data_reg.pulses_total    <= pulse_acc_next;
                        m_data_reg.volume_total_ul <= vol_acc_next;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `FRLC_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `FRLC_ASSERT_NOW(a_alert_only_in_leak, aclk, aresetn, m_valid && m_data.leak_alert, m_data.flow_mode == frlc_pkg::MODE_LEAK)
    `FRLC_ASSERT_NOW(a_idle_no_flow, aclk, aresetn, m_valid && (m_data.flow_mode == frlc_pkg::MODE_IDLE), !m_data.flow_present)
    `FRLC_ASSERT_NEXT(a_hold_when_full, aclk, aresetn, (state_reg == S_FIN) && m_valid && !m_ready, state_reg == S_FIN)

endmodule
`default_nettype wire
